### rtl/cfa_pkg.sv
// Package for the contiguous fit allocator.
// Holds the request and response payload types and the operation, fit and status codes.
// No dependencies.
package cfa_pkg;

	// Operation codes
	localparam logic [1:0] OP_REQUEST = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_COMPACT = 2'd2;

	// Fit policies
	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST  = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;

	// Response status
	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_NOFIT   = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [6:0]  proc_id;
		logic [10:0] req_size;
		logic [1:0]  fit_mode;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [9:0]  block_start;
		logic [9:0]  block_end;
		logic [10:0] free_units;
	} rsp_t;

endpackage

### rtl/contiguous_fit_allocator.sv
// Top level of the contiguous fit allocator: sequencer, header chain, owner and process tables.
// Depends on cfa_pkg.
//
// The allocator keeps a chain of block headers, one per block start, in a header memory with
// one write port and one registered read port; every valid operation walks that chain from unit 0
// one header at a time. A request reads and evaluates each block header in turn, then checks
// the result, splits the chosen block, updates the tables and responds. A release first frees
// the block, then walks the chain again, merging each free block with its free right neighbors,
// and then responds. A compaction reads each block in turn and moves allocated blocks down.
// The command side stalls while an operation runs; a finished response waits in its output
// register while the next command is accepted. No clearing pass is needed after reset: unit 0
// reads as one free block of MEM_UNITS until first written, and no other header is read before
// it is written.
module contiguous_fit_allocator #(
	parameter int MEM_UNITS = 1024,
	parameter int NUM_PROCS = 128
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  cfa_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output cfa_pkg::rsp_t rsp
);

	localparam int AW = $clog2(MEM_UNITS);
	localparam int CW = AW + 1;
	localparam int HW = CW + 1;
	localparam int PW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
	localparam logic [CW-1:0] MEM_N = CW'(MEM_UNITS);

	typedef enum logic [17:0] {
		S_IDLE   = 18'h00001,
		S_CHK    = 18'h00002,
		S_RQ_RD  = 18'h00004,
		S_RQ_EV  = 18'h00008,
		S_RQ_END = 18'h00010,
		S_RQ_HD  = 18'h00020,
		S_RL_ST  = 18'h00040,
		S_RL_RD  = 18'h00080,
		S_RL_FIX = 18'h00100,
		S_M_RD   = 18'h00200,
		S_M_EV   = 18'h00400,
		S_M_RDN  = 18'h00800,
		S_M_EVN  = 18'h01000,
		S_M_WR   = 18'h02000,
		S_M_ADV  = 18'h04000,
		S_CP_RD  = 18'h08000,
		S_CP_EV  = 18'h10000,
		S_FIN    = 18'h20000
	} state_t;

	state_t state_q;

	// Storage
	logic signed [HW-1:0] hdr_mem [MEM_UNITS];
	logic [6:0]           own_mem [MEM_UNITS];
	logic [AW-1:0]        st_mem  [NUM_PROCS];
	logic [NUM_PROCS-1:0] act_q;
	logic                 init_q;

	logic signed [HW-1:0] hdr_rd_q;
	logic                 rd0_q;
	logic [6:0]           own_rd_q;
	logic [AW-1:0]        st_rd_q;
	logic [AW-1:0]        rd_addr_q;

	// Command and walk registers
	logic [1:0]           op_q;
	logic [6:0]           pid_q;
	logic [10:0]          size_raw_q;
	logic [1:0]           mode_q;
	logic [CW-1:0]        i_q;
	logic [CW-1:0]        nx_q;
	logic signed [HW-1:0] v_q;
	logic [AW-1:0]        pick_q;
	logic [CW-1:0]        psz_q;
	logic                 found_q;
	logic [CW-1:0]        top_q;
	logic [AW-1:0]        s_q;

	logic [1:0]           res_st_q;
	logic [CW-1:0]        res_s_q;
	logic [CW-1:0]        res_e_q;
	logic [CW-1:0]        res_f_q;
	logic                 rsp_valid_q;
	cfa_pkg::rsp_t        rsp_q;

	// Write port controls
	logic                 hdr_we;
	logic [AW-1:0]        hdr_wa;
	logic signed [HW-1:0] hdr_wd;
	logic                 own_we;
	logic [AW-1:0]        own_wa;
	logic                 st_we;
	logic [PW-1:0]        st_wa;
	logic [AW-1:0]        st_wd;

	// Shared header decode
	logic signed [HW-1:0] hv;
	logic                 hv_pos;
	logic                 hv_neg;
	logic [CW-1:0]        hv_mag;
	logic [CW-1:0]        len;
	logic [CW-1:0]        size_q;
	logic [PW-1:0]        pidx;
	logic [CW-1:0]        i_nx;
	logic                 fit;
	logic                 take;
	logic                 bad_req;
	logic                 bad_rel;
	logic [CW-1:0]        split_a;

	assign size_q  = CW'(size_raw_q);
	assign pidx    = PW'(pid_q);
	assign hv      = rd0_q ? HW'(MEM_UNITS) : hdr_rd_q;
	assign hv_neg  = hv[HW-1];
	assign hv_pos  = !hv[HW-1] && (hv != '0);
	assign hv_mag  = hv_neg ? CW'(-hv) : CW'(hv);
	assign len     = (hv == '0) ? CW'(1) : hv_mag;
	assign i_nx    = i_q + len;
	assign fit     = hv_pos && (hv_mag >= size_q);
	assign take    = fit && (!found_q || (mode_q == cfa_pkg::FIT_BEST && hv_mag < psz_q)
		|| (mode_q == cfa_pkg::FIT_WORST && hv_mag > psz_q));
	assign bad_req = (size_raw_q == '0) || (32'(size_raw_q) > 32'(MEM_UNITS))
		|| (mode_q > cfa_pkg::FIT_WORST) || (32'(pid_q) >= 32'(NUM_PROCS)) || act_q[pidx];
	assign bad_rel = (32'(pid_q) >= 32'(NUM_PROCS)) || !act_q[pidx];
	assign split_a = CW'(pick_q) + size_q;

	// Drive memory writes from the current step
	always_comb begin
		hdr_we = 1'b0;
		hdr_wa = '0;
		hdr_wd = '0;
		own_we = 1'b0;
		own_wa = '0;
		st_we  = 1'b0;
		st_wa  = pidx;
		st_wd  = pick_q;
		case (state_q)
			S_RQ_END: begin
				hdr_we = found_q && (psz_q > size_q) && (split_a < MEM_N);
				hdr_wa = AW'(split_a);
				hdr_wd = HW'(psz_q - size_q);
			end
			S_RQ_HD: begin
				hdr_we = 1'b1;
				hdr_wa = pick_q;
				hdr_wd = -$signed({1'b0, size_q});
				own_we = 1'b1;
				own_wa = pick_q;
				st_we  = 1'b1;
			end
			S_RL_FIX: begin
				hdr_we = hv_neg;
				hdr_wa = s_q;
				hdr_wd = -hv;
			end
			S_M_EVN: begin
				hdr_we = hv_pos;
				hdr_wa = AW'(nx_q);
				hdr_wd = '0;
			end
			S_M_WR: begin
				hdr_we = 1'b1;
				hdr_wa = AW'(i_q);
				hdr_wd = v_q;
			end
			S_CP_EV: begin
				hdr_we = hv_neg;
				hdr_wa = AW'(top_q);
				hdr_wd = hv;
				own_we = hv_neg;
				own_wa = AW'(top_q);
				st_we  = hv_neg;
				st_wa  = PW'(own_rd_q);
				st_wd  = AW'(top_q);
			end
			S_FIN: begin
				hdr_we = (op_q == cfa_pkg::OP_COMPACT) && (top_q < MEM_N);
				hdr_wa = AW'(top_q);
				hdr_wd = HW'(MEM_N - top_q);
			end
			default: begin
			end
		endcase
	end

	// Memories: one write, registered read
	always_ff @(posedge clk) begin
		if (hdr_we) begin
			hdr_mem[hdr_wa] <= hdr_wd;
		end
		if (own_we) begin
			own_mem[own_wa] <= (state_q == S_CP_EV) ? own_rd_q : pid_q;
		end
		if (st_we) begin
			st_mem[st_wa] <= st_wd;
		end
		hdr_rd_q <= hdr_mem[rd_addr_q];
		own_rd_q <= own_mem[rd_addr_q];
		st_rd_q  <= st_mem[pidx];
	end

	// Unit 0 reads as the full free block until first written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= 1'b0;
			rd0_q  <= 1'b0;
		end else begin
			rd0_q <= (rd_addr_q == '0) && !init_q;
			if (hdr_we && hdr_wa == '0) begin
				init_q <= 1'b1;
			end
		end
	end

	// Payload and walk registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q       <= cmd.opcode;
				pid_q      <= cmd.proc_id;
				size_raw_q <= cmd.req_size;
				mode_q     <= cmd.fit_mode;
			end
			S_CHK: begin
				res_st_q  <= cfa_pkg::ST_DONE;
				res_s_q   <= '0;
				res_e_q   <= '0;
				res_f_q   <= '0;
				i_q       <= '0;
				top_q     <= '0;
				found_q   <= 1'b0;
				rd_addr_q <= '0;
				if ((op_q == cfa_pkg::OP_REQUEST && bad_req)
					|| (op_q == cfa_pkg::OP_RELEASE && bad_rel)
					|| op_q > cfa_pkg::OP_COMPACT) begin
					res_st_q <= cfa_pkg::ST_INVALID;
				end
			end
			S_RQ_EV: begin
				if (take) begin
					pick_q  <= AW'(i_q);
					psz_q   <= hv_mag;
					found_q <= 1'b1;
				end
				i_q       <= i_nx;
				rd_addr_q <= AW'(i_nx);
			end
			S_RQ_END: begin
				if (!found_q) begin
					res_st_q <= cfa_pkg::ST_NOFIT;
				end
			end
			S_RQ_HD: begin
				res_s_q <= CW'(pick_q);
				res_e_q <= split_a - CW'(1);
				res_f_q <= psz_q;
			end
			S_RL_ST: begin
				s_q       <= st_rd_q;
				rd_addr_q <= st_rd_q;
			end
			S_RL_FIX: begin
				rd_addr_q <= '0;
			end
			S_M_EV: begin
				v_q  <= hv;
				nx_q <= i_nx;
				if (i_nx < MEM_N) begin
					rd_addr_q <= AW'(i_nx);
				end
			end
			S_M_EVN: begin
				// Absorb the right neighbor only when it is free
				if (hv_pos) begin
					v_q  <= v_q + hv;
					nx_q <= nx_q + hv_mag;
				end
			end
			S_M_WR: begin
				rd_addr_q <= AW'(nx_q);
			end
			S_M_ADV: begin
				if (CW'(s_q) >= i_q && CW'(s_q) < nx_q) begin
					res_s_q <= i_q;
					res_e_q <= nx_q - CW'(1);
					res_f_q <= nx_q - i_q;
				end
				i_q       <= nx_q;
				rd_addr_q <= AW'(nx_q);
			end
			S_CP_EV: begin
				if (hv_neg) begin
					top_q <= top_q + len;
				end
				i_q       <= i_nx;
				rd_addr_q <= AW'(i_nx);
			end
			S_FIN: begin
				if (op_q == cfa_pkg::OP_COMPACT && res_st_q == cfa_pkg::ST_DONE
					&& top_q < MEM_N) begin
					res_s_q <= top_q;
					res_e_q <= MEM_N - CW'(1);
					res_f_q <= MEM_N - top_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer, process active bits and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			act_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					case (op_q)
						cfa_pkg::OP_REQUEST: state_q <= bad_req ? S_FIN : S_RQ_RD;
						cfa_pkg::OP_RELEASE: state_q <= bad_rel ? S_FIN : S_RL_ST;
						cfa_pkg::OP_COMPACT: state_q <= S_CP_RD;
						default:             state_q <= S_FIN;
					endcase
				end
				S_RQ_RD: state_q <= S_RQ_EV;
				S_RQ_EV: begin
					if ((fit && mode_q == cfa_pkg::FIT_FIRST) || i_nx >= MEM_N) begin
						state_q <= S_RQ_END;
					end else begin
						state_q <= S_RQ_RD;
					end
				end
				S_RQ_END: state_q <= found_q ? S_RQ_HD : S_FIN;
				S_RQ_HD: begin
					act_q[pidx] <= 1'b1;
					state_q     <= S_FIN;
				end
				S_RL_ST: state_q <= S_RL_RD;
				S_RL_RD: state_q <= S_RL_FIX;
				S_RL_FIX: begin
					act_q[pidx] <= 1'b0;
					state_q     <= S_M_RD;
				end
				S_M_RD: state_q <= S_M_EV;
				S_M_EV: state_q <= (hv_pos && i_nx < MEM_N) ? S_M_RDN : S_M_ADV;
				S_M_RDN: state_q <= S_M_EVN;
				S_M_EVN: state_q <= hv_pos ? S_M_WR : S_M_ADV;
				S_M_WR: state_q <= (nx_q < MEM_N) ? S_M_RDN : S_M_ADV;
				S_M_ADV: state_q <= (nx_q >= MEM_N) ? S_FIN : S_M_RD;
				S_CP_RD: state_q <= S_CP_EV;
				S_CP_EV: state_q <= (i_nx >= MEM_N) ? S_FIN : S_CP_RD;
				S_FIN: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Load the response when leaving the final step
	always_ff @(posedge clk) begin
		if (state_q == S_FIN && (!rsp_valid_q || !rsp_stall)) begin
			rsp_q.status      <= res_st_q;
			rsp_q.block_start <= 10'(res_s_q);
			rsp_q.block_end   <= 10'(res_e_q);
			rsp_q.free_units  <= 11'(res_f_q);
			if (op_q == cfa_pkg::OP_COMPACT && res_st_q == cfa_pkg::ST_DONE
				&& top_q < MEM_N) begin
				rsp_q.block_start <= 10'(top_q);
				rsp_q.block_end   <= 10'(MEM_N - CW'(1));
				rsp_q.free_units  <= 11'(MEM_N - top_q);
			end
		end
	end

	assign cmd_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### rtl/cfa_checker.sv
// Port-level checker for the contiguous fit allocator, bound to the top level.
// Depends on cfa_pkg.
module cfa_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          cmd_valid,
	input logic          cmd_stall,
	input cfa_pkg::cmd_t cmd,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input cfa_pkg::rsp_t rsp
);

	// Hold a stalled response
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// Go busy after taking a request
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("request taken while idle state kept");

	// Failed requests report zero fields
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != cfa_pkg::ST_DONE |->
		rsp.block_start == '0 && rsp.block_end == '0 && rsp.free_units == '0)
		else $error("failure response carries data");

	// A new response follows work in progress
	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(cmd_stall))
		else $error("response without request in progress");

endmodule

bind contiguous_fit_allocator cfa_checker u_cfa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.cmd       (cmd),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

### sim/contiguous_fit_allocator_test.sv
// Testbench for contiguous_fit_allocator: allocation, release with merging and compaction.
// Predicts each response with its own header-chain and process-table model; depends on cfa_pkg.
`timescale 1ns / 100ps

module contiguous_fit_allocator_test;

	localparam int MEM = 1024;
	localparam int NPROC = 128;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cfa_pkg::cmd_t cmd;
	logic rsp_valid;
	logic rsp_stall;
	cfa_pkg::rsp_t rsp;

	contiguous_fit_allocator u_dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	// Predicted allocator state
	int hdr [MEM];
	bit pr_active [NPROC];
	int pr_start [NPROC];

	cfa_pkg::cmd_t pending_requests [$];
	cfa_pkg::rsp_t expected_rsp [$];
	int errors;
	bit busy_free;
	bit drain_hold;
	bit all_sent;

	function automatic int span(int v);
		int a;
		a = v < 0 ? -v : v;
		return a == 0 ? 1 : a;
	endfunction

	function automatic cfa_pkg::rsp_t mk(logic [1:0] st, int s, int e, int f);
		cfa_pkg::rsp_t r;
		r.status = st;
		r.block_start = s[9:0];
		r.block_end = e[9:0];
		r.free_units = f[10:0];
		return r;
	endfunction

	function automatic cfa_pkg::rsp_t alloc_block(int pid, int size, logic [1:0] mode);
		int i, pick, pick_sz, v;
		bit found;
		if (size == 0 || size > MEM || mode > cfa_pkg::FIT_WORST || pr_active[pid])
			return mk(cfa_pkg::ST_INVALID, 0, 0, 0);
		i = 0; pick = 0; pick_sz = 0; found = 0;
		while (i < MEM) begin
			v = hdr[i];
			if (v > 0 && v >= size) begin
				if (!found || (mode == cfa_pkg::FIT_BEST && v < pick_sz) ||
						(mode == cfa_pkg::FIT_WORST && v > pick_sz)) begin
					pick = i; pick_sz = v; found = 1;
				end
				if (mode == cfa_pkg::FIT_FIRST)
					break;
			end
			i += span(v);
		end
		if (!found)
			return mk(cfa_pkg::ST_NOFIT, 0, 0, 0);
		if (pick_sz > size && pick + size < MEM)
			hdr[pick + size] = pick_sz - size;
		hdr[pick] = -size;
		pr_active[pid] = 1;
		pr_start[pid] = pick;
		return mk(cfa_pkg::ST_DONE, pick, pick + size - 1, pick_sz);
	endfunction

	function automatic cfa_pkg::rsp_t free_block(int pid);
		int i, s, v, nx, len;
		if (!pr_active[pid])
			return mk(cfa_pkg::ST_INVALID, 0, 0, 0);
		s = pr_start[pid];
		if (hdr[s] < 0)
			hdr[s] = -hdr[s];
		pr_active[pid] = 0;
		// merge neighbor free blocks
		i = 0;
		while (i < MEM) begin
			v = hdr[i];
			nx = i + span(v);
			if (v > 0 && nx < MEM && hdr[nx] > 0) begin
				hdr[i] = v + hdr[nx];
				hdr[nx] = 0;
			end else begin
				i = nx;
			end
		end
		i = 0;
		while (i < MEM) begin
			len = span(hdr[i]);
			if (s >= i && s < i + len)
				return mk(cfa_pkg::ST_DONE, i, i + len - 1, len);
			i += len;
		end
		return mk(cfa_pkg::ST_DONE, 0, 0, 0);
	endfunction

	function automatic cfa_pkg::rsp_t compact_memory();
		int i, top, v, len, p;
		i = 0; top = 0;
		while (i < MEM) begin
			v = hdr[i];
			len = span(v);
			hdr[i] = 0;
			if (v < 0) begin
				hdr[top] = v;
				for (p = 0; p < NPROC; p++)
					if (pr_active[p] && pr_start[p] == i)
						pr_start[p] = top;
				top += len;
			end
			i += len;
		end
		if (top < MEM) begin
			hdr[top] = MEM - top;
			return mk(cfa_pkg::ST_DONE, top, MEM - 1, MEM - top);
		end
		return mk(cfa_pkg::ST_DONE, 0, 0, 0);
	endfunction

	function automatic cfa_pkg::rsp_t predict_response(cfa_pkg::cmd_t c);
		case (c.opcode)
			cfa_pkg::OP_REQUEST: return alloc_block(c.proc_id, c.req_size, c.fit_mode);
			cfa_pkg::OP_RELEASE: return free_block(c.proc_id);
			cfa_pkg::OP_COMPACT: return compact_memory();
			default: return mk(cfa_pkg::ST_INVALID, 0, 0, 0);
		endcase
	endfunction

	function automatic cfa_pkg::cmd_t mk_cmd(logic [1:0] op, int pid, int size,
			logic [1:0] mode);
		cfa_pkg::cmd_t c;
		c.opcode = op;
		c.proc_id = pid[6:0];
		c.req_size = size[10:0];
		c.fit_mode = mode;
		return c;
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Driver: present the next request, hold it while stalled
	always @(negedge clk) begin
		if (!arst_n) begin
			cmd_valid <= 0;
		end else if (cmd_valid && cmd_stall) begin
			// hold
		end else begin
			if (cmd_valid && !cmd_stall)
				pending_requests.pop_front();
			if (pending_requests.size() > 0 && !drain_hold &&
					(busy_free || $urandom_range(99) >= 24)) begin
				cmd_valid <= 1;
				cmd <= pending_requests[0];
			end else begin
				cmd_valid <= 0;
			end
		end
	end

	// Receiver back-pressure
	always @(negedge clk)
		rsp_stall <= arst_n && !busy_free && $urandom_range(99) < 24;

	// Monitor: predict on accepted requests, check accepted responses
	always @(posedge clk) begin
		cfa_pkg::rsp_t exp_r;
		if (arst_n) begin
			if (cmd_valid && !cmd_stall)
				expected_rsp.push_back(predict_response(cmd));
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp.size() == 0) begin
					$display("%0t: unexpected response %h", $time, rsp);
					errors++;
				end else begin
					exp_r = expected_rsp.pop_front();
					if (rsp.status !== exp_r.status || rsp.block_start !== exp_r.block_start ||
							rsp.block_end !== exp_r.block_end ||
							rsp.free_units !== exp_r.free_units) begin
						$display("%0t: mismatch expected %0d/%0d/%0d/%0d actual %0d/%0d/%0d/%0d",
							$time, exp_r.status, exp_r.block_start, exp_r.block_end,
							exp_r.free_units, rsp.status, rsp.block_start, rsp.block_end,
							rsp.free_units);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		int k, r, pid, size;
		cfa_pkg::cmd_t c;
		errors = 0; busy_free = 0; drain_hold = 0; all_sent = 0;
		cmd_valid = 0; rsp_stall = 0; cmd = '0;
		for (k = 0; k < MEM; k++) hdr[k] = 0;
		hdr[0] = MEM;
		for (k = 0; k < NPROC; k++) begin pr_active[k] = 0; pr_start[k] = 0; end
		arst_n = 0;
		repeat (2) @(posedge clk);
		#1 arst_n = 1;

		// Directed: extremes, every operation, bad requests, exact fit, ties, full memory
		pending_requests.push_back(mk_cmd(cfa_pkg::OP_COMPACT, 0, 0, cfa_pkg::FIT_FIRST));
		pending_requests.push_back(mk_cmd(cfa_pkg::OP_REQUEST, 0, 0, cfa_pkg::FIT_FIRST));
		pending_requests.push_back(mk_cmd(cfa_pkg::OP_REQUEST, 0, 1025, cfa_pkg::FIT_FIRST));
		pending_requests.push_back(mk_cmd(cfa_pkg::OP_REQUEST, 0, 2047, cfa_pkg::FIT_BEST));
		pending_requests.push_back(mk_cmd(cfa_pkg::OP_REQUEST, 0, 10, 3));
		pending_requests.push_back(mk_cmd(cfa_pkg::OP_RELEASE, 127, 0, cfa_pkg::FIT_FIRST));
		pending_requests.push_back(mk_cmd(3, 127, 2047, 3));
		pending_requests.push_back(mk_cmd(cfa_pkg::OP_REQUEST, 127, 1024, cfa_pkg::FIT_WORST));
		pending_requests.push_back(mk_cmd(cfa_pkg::OP_REQUEST, 1, 1, cfa_pkg::FIT_FIRST));
		pending_requests.push_back(mk_cmd(cfa_pkg::OP_COMPACT, 0, 0, cfa_pkg::FIT_FIRST));
		pending_requests.push_back(mk_cmd(cfa_pkg::OP_REQUEST, 127, 5, cfa_pkg::FIT_FIRST));
		pending_requests.push_back(mk_cmd(cfa_pkg::OP_RELEASE, 127, 0, cfa_pkg::FIT_FIRST));
		pending_requests.push_back(mk_cmd(cfa_pkg::OP_REQUEST, 1, 100, cfa_pkg::FIT_FIRST));
		pending_requests.push_back(mk_cmd(cfa_pkg::OP_REQUEST, 2, 100, cfa_pkg::FIT_FIRST));
		pending_requests.push_back(mk_cmd(cfa_pkg::OP_REQUEST, 3, 100, cfa_pkg::FIT_FIRST));
		pending_requests.push_back(mk_cmd(cfa_pkg::OP_REQUEST, 4, 100, cfa_pkg::FIT_FIRST));
		pending_requests.push_back(mk_cmd(cfa_pkg::OP_RELEASE, 1, 0, cfa_pkg::FIT_FIRST));
		pending_requests.push_back(mk_cmd(cfa_pkg::OP_RELEASE, 3, 0, cfa_pkg::FIT_FIRST));
		pending_requests.push_back(mk_cmd(cfa_pkg::OP_REQUEST, 5, 50, cfa_pkg::FIT_BEST));
		pending_requests.push_back(mk_cmd(cfa_pkg::OP_REQUEST, 6, 100, cfa_pkg::FIT_BEST));
		pending_requests.push_back(mk_cmd(cfa_pkg::OP_REQUEST, 7, 30, cfa_pkg::FIT_WORST));
		pending_requests.push_back(mk_cmd(cfa_pkg::OP_RELEASE, 2, 0, cfa_pkg::FIT_FIRST));
		pending_requests.push_back(mk_cmd(cfa_pkg::OP_COMPACT, 0, 0, cfa_pkg::FIT_FIRST));
		pending_requests.push_back(mk_cmd(cfa_pkg::OP_REQUEST, 8, 624, cfa_pkg::FIT_FIRST));

		// Hold the sender until the directed part has drained
		wait (pending_requests.size() == 0 && !cmd_valid);
		drain_hold = 1;
		wait (expected_rsp.size() == 0);
		@(negedge clk);
		drain_hold = 0;

		// Random: mostly well-formed traffic on a bounded set of processes
		for (k = 0; k < 560; k++) begin
			r = $urandom_range(99);
			pid = $urandom_range(99) < 90 ? $urandom_range(15) : $urandom_range(127);
			if ($urandom_range(9) == 0)
				size = $urandom_range(2047);
			else if ($urandom_range(9) == 0)
				size = $urandom_range(1024, 300);
			else
				size = $urandom_range(80, 1);
			if (r < 50)
				c = mk_cmd(cfa_pkg::OP_REQUEST, pid, size,
					$urandom_range(99) < 95 ? $urandom_range(2) : 3);
			else if (r < 88)
				c = mk_cmd(cfa_pkg::OP_RELEASE, pid, $urandom_range(2047),
					$urandom_range(3));
			else if (r < 97)
				c = mk_cmd(cfa_pkg::OP_COMPACT, $urandom_range(127), $urandom_range(2047),
					$urandom_range(3));
			else
				c = mk_cmd(3, $urandom_range(127), $urandom_range(2047), $urandom_range(3));
			pending_requests.push_back(c);
			// stretch with no idling
			if (k == 200) begin
				wait (pending_requests.size() == 0);
				busy_free = 1;
			end
			if (k == 300) begin
				wait (pending_requests.size() == 0);
				busy_free = 0;
			end
		end
		wait (pending_requests.size() == 0 && !cmd_valid);
		all_sent = 1;
		wait (expected_rsp.size() == 0);
		repeat (4200) @(posedge clk);
		if (errors == 0 && expected_rsp.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog
	initial begin
		#300000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
